// ----- sv/fmd_pkg.sv -----
// Shared types and constants for the framed message deframer.
// Holds the phase encoding, the register map, the configuration and result
// structs. Depends on nothing.
package fmd_pkg;

   // Largest payload length a frame may declare (buffer size less header)
   localparam int unsigned BUF_SIZE   = 512;
   localparam int unsigned MAX_LENGTH = BUF_SIZE - 8;

   localparam int unsigned BYTE_W   = 8;
   localparam int unsigned LENGTH_W = 16;
   localparam int unsigned DROP_W   = 32;
   localparam int unsigned CSR_AW   = 5;
   localparam int unsigned CSR_DW   = 32;
   localparam int unsigned CSR_IW   = 3;

   // Register indexes; byte address is four times the index
   typedef enum logic [CSR_IW-1:0] {
      REG_START_BYTE    = 3'd0,
      REG_END_BYTE      = 3'd1,
      REG_OWN_ADDRESS   = 3'd2,
      REG_SOURCE_CODE_A = 3'd3,
      REG_SOURCE_CODE_B = 3'd4,
      REG_SOURCE_CODE_C = 3'd5,
      REG_SOURCE_CODE_D = 3'd6,
      REG_SOURCE_CODE_E = 3'd7
   } reg_index_type;

   // Register reset values
   localparam logic [BYTE_W-1:0] RST_START_BYTE    = 8'd2;
   localparam logic [BYTE_W-1:0] RST_END_BYTE      = 8'd3;
   localparam logic [BYTE_W-1:0] RST_OWN_ADDRESS   = 8'd65;
   localparam logic [BYTE_W-1:0] RST_SOURCE_CODE_A = 8'd66;
   localparam logic [BYTE_W-1:0] RST_SOURCE_CODE_B = 8'd67;
   localparam logic [BYTE_W-1:0] RST_SOURCE_CODE_C = 8'd68;
   localparam logic [BYTE_W-1:0] RST_SOURCE_CODE_D = 8'd69;
   localparam logic [BYTE_W-1:0] RST_SOURCE_CODE_E = 8'd70;

   // Parser phases, one-hot
   typedef enum logic [8:0] {
      PH_IDLE   = 9'b000000001,
      PH_DEST   = 9'b000000010,
      PH_SRC    = 9'b000000100,
      PH_COUNT  = 9'b000001000,
      PH_LEN_HI = 9'b000010000,
      PH_LEN_LO = 9'b000100000,
      PH_DATA   = 9'b001000000,
      PH_SUM    = 9'b010000000,
      PH_END    = 9'b100000000
   } phase_type;

   // Configuration as seen by the parser
   typedef struct packed {
      logic [BYTE_W-1:0] start_byte;
      logic [BYTE_W-1:0] end_byte;
      logic [BYTE_W-1:0] own_address;
      logic [BYTE_W-1:0] source_code_a;
      logic [BYTE_W-1:0] source_code_b;
      logic [BYTE_W-1:0] source_code_c;
      logic [BYTE_W-1:0] source_code_d;
      logic [BYTE_W-1:0] source_code_e;
   } cfg_type;

   // One result word
   typedef struct packed {
      logic                message_done;
      logic                error_now;
      logic                payload_valid;
      logic [BYTE_W-1:0]   payload_byte;
      logic [LENGTH_W-1:0] payload_offset;
      logic [BYTE_W-1:0]   source_seen;
      logic [BYTE_W-1:0]   count_seen;
      logic [DROP_W-1:0]   drop_total;
   } result_type;

endpackage

// ----- sv/fmd_if.sv -----
// Valid/ready channel interfaces for received bytes and parse results.
// Depends on fmd_pkg.
interface fmd_req_if;
   logic                     valid;
   logic                     ready;
   logic [fmd_pkg::BYTE_W-1:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

interface fmd_rsp_if;
   logic                         valid;
   logic                         ready;
   logic                         message_done;
   logic                         error_now;
   logic                         payload_valid;
   logic [fmd_pkg::BYTE_W-1:0]   payload_byte;
   logic [fmd_pkg::LENGTH_W-1:0] payload_offset;
   logic [fmd_pkg::BYTE_W-1:0]   source_seen;
   logic [fmd_pkg::BYTE_W-1:0]   count_seen;
   logic [fmd_pkg::DROP_W-1:0]   drop_total;

   modport source (output valid, output message_done, output error_now,
                   output payload_valid, output payload_byte, output payload_offset,
                   output source_seen, output count_seen, output drop_total,
                   input ready);
   modport sink   (input valid, input message_done, input error_now,
                   input payload_valid, input payload_byte, input payload_offset,
                   input source_seen, input count_seen, input drop_total,
                   output ready);
endinterface

// ----- sv/framed_message_deframer_unit.sv -----
// Framed message deframer: byte-stream frame parser with additive checksum.
// Usage:
//   req_ch carries one received byte per word (valid/ready); rsp_ch returns
//   exactly one result word per accepted byte, in order: frame done, error,
//   payload byte with its offset, latched source and count, drop total.
//   The APB-style port (psel/penable/pwrite/paddr/pwdata/prdata/pready) holds
//   eight byte registers at byte addresses 0,4,..,28; write it only while idle.
// Timing:
//   A byte is parsed in the cycle it is accepted; its result is registered in
//   the result buffer and shows on rsp_ch once the words ahead of it are taken.
//   Throughput is one byte per cycle while the result buffer has space.
//   A two-entry result buffer lets req_ch keep accepting while one result
//   waits; req_ch.ready drops only when both entries are full, so a stalled
//   receiver backs up the sender after two words.
// Reset (synchronous, active high): parser returns to hunting for the start
//   byte, all counters and latched fields clear, registers take their
//   defaults, and the result buffer empties.
// Depends on fmd_pkg, fmd_if, fmd_csr, fmd_parser, fmd_out_buf.
module framed_message_deframer_unit (
   input  logic                       clock,
   input  logic                       reset,
   fmd_req_if.sink                    req_ch,
   fmd_rsp_if.source                  rsp_ch,
   input  logic                       psel,
   input  logic                       penable,
   input  logic                       pwrite,
   input  logic [fmd_pkg::CSR_AW-1:0] paddr,
   input  logic [fmd_pkg::CSR_DW-1:0] pwdata,
   output logic [fmd_pkg::CSR_DW-1:0] prdata,
   output logic                       pready
);
   import fmd_pkg::*;

   cfg_type    cfg;
   result_type parse_result;
   result_type out_result;
   logic       space;
   logic       accept;

   assign req_ch.ready = space;
   assign accept       = req_ch.valid && space;

   // Configuration registers
   fmd_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // Parse state machine
   fmd_parser u_parser (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg),
      .accept  (accept),
      .rx_byte (req_ch.rx_byte),
      .result  (parse_result)
   );

   // Result register and skid slot
   fmd_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .push      (accept),
      .push_data (parse_result),
      .space     (space),
      .out_valid (rsp_ch.valid),
      .out_ready (rsp_ch.ready),
      .out_data  (out_result)
   );

   // Drive the result channel fields
   assign rsp_ch.message_done   = out_result.message_done;
   assign rsp_ch.error_now      = out_result.error_now;
   assign rsp_ch.payload_valid  = out_result.payload_valid;
   assign rsp_ch.payload_byte   = out_result.payload_byte;
   assign rsp_ch.payload_offset = out_result.payload_offset;
   assign rsp_ch.source_seen    = out_result.source_seen;
   assign rsp_ch.count_seen     = out_result.count_seen;
   assign rsp_ch.drop_total     = out_result.drop_total;

endmodule

// ----- sv/fmd_csr.sv -----
// APB-style register file holding the framing bytes, address and source codes.
// Depends on fmd_pkg.
module fmd_csr (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic [fmd_pkg::CSR_AW-1:0]  paddr,
   input  logic [fmd_pkg::CSR_DW-1:0]  pwdata,
   output logic [fmd_pkg::CSR_DW-1:0]  prdata,
   output logic                        pready,
   output fmd_pkg::cfg_type            cfg
);
   import fmd_pkg::*;

   cfg_type       cfg_ff;
   cfg_type       cfg_in;
   reg_index_type index;
   logic          write_en;
   logic [BYTE_W-1:0] read_byte;

   assign pready   = 1'b1;
   assign index    = reg_index_type'(paddr[CSR_AW-1:2]);
   assign write_en = psel && penable && pwrite && pready;

   // Decode a write into the addressed byte
   always_comb begin
      cfg_in = cfg_ff;
      if (write_en) begin
         case (index)
            REG_START_BYTE:    cfg_in.start_byte    = pwdata[BYTE_W-1:0];
            REG_END_BYTE:      cfg_in.end_byte      = pwdata[BYTE_W-1:0];
            REG_OWN_ADDRESS:   cfg_in.own_address   = pwdata[BYTE_W-1:0];
            REG_SOURCE_CODE_A: cfg_in.source_code_a = pwdata[BYTE_W-1:0];
            REG_SOURCE_CODE_B: cfg_in.source_code_b = pwdata[BYTE_W-1:0];
            REG_SOURCE_CODE_C: cfg_in.source_code_c = pwdata[BYTE_W-1:0];
            REG_SOURCE_CODE_D: cfg_in.source_code_d = pwdata[BYTE_W-1:0];
            REG_SOURCE_CODE_E: cfg_in.source_code_e = pwdata[BYTE_W-1:0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.start_byte    <= RST_START_BYTE;
         cfg_ff.end_byte      <= RST_END_BYTE;
         cfg_ff.own_address   <= RST_OWN_ADDRESS;
         cfg_ff.source_code_a <= RST_SOURCE_CODE_A;
         cfg_ff.source_code_b <= RST_SOURCE_CODE_B;
         cfg_ff.source_code_c <= RST_SOURCE_CODE_C;
         cfg_ff.source_code_d <= RST_SOURCE_CODE_D;
         cfg_ff.source_code_e <= RST_SOURCE_CODE_E;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Read back the addressed byte
   always_comb begin
      case (index)
         REG_START_BYTE:    read_byte = cfg_ff.start_byte;
         REG_END_BYTE:      read_byte = cfg_ff.end_byte;
         REG_OWN_ADDRESS:   read_byte = cfg_ff.own_address;
         REG_SOURCE_CODE_A: read_byte = cfg_ff.source_code_a;
         REG_SOURCE_CODE_B: read_byte = cfg_ff.source_code_b;
         REG_SOURCE_CODE_C: read_byte = cfg_ff.source_code_c;
         REG_SOURCE_CODE_D: read_byte = cfg_ff.source_code_d;
         REG_SOURCE_CODE_E: read_byte = cfg_ff.source_code_e;
         default:           read_byte = '0;
      endcase
   end

   assign prdata = {{(CSR_DW-BYTE_W){1'b0}}, read_byte};
   assign cfg    = cfg_ff;

endmodule

// ----- sv/fmd_parser.sv -----
// Frame parser state machine: consumes one accepted byte and forms its result.
// Depends on fmd_pkg.
module fmd_parser (
   input  logic                       clock,
   input  logic                       reset,
   input  fmd_pkg::cfg_type           cfg,
   input  logic                       accept,
   input  logic [fmd_pkg::BYTE_W-1:0] rx_byte,
   output fmd_pkg::result_type        result
);
   import fmd_pkg::*;

   phase_type           phase_ff,  phase_in;
   logic [LENGTH_W-1:0] pos_ff,    pos_in;
   logic [LENGTH_W-1:0] len_ff,    len_in;
   logic [BYTE_W-1:0]   sum_ff,    sum_in;
   logic                stop_ff,   stop_in;
   logic [BYTE_W-1:0]   src_ff,    src_in;
   logic [BYTE_W-1:0]   cnt_ff,    cnt_in;
   logic [DROP_W-1:0]   drop_ff,   drop_in;
   logic [LENGTH_W-1:0] pos_inc;
   logic [LENGTH_W-1:0] len_full;
   logic                src_match;

   assign pos_inc   = pos_ff + LENGTH_W'(1);
   assign len_full  = len_ff | {{(LENGTH_W-BYTE_W){1'b0}}, rx_byte};
   assign src_match = (rx_byte == cfg.source_code_a) || (rx_byte == cfg.source_code_b) ||
                      (rx_byte == cfg.source_code_c) || (rx_byte == cfg.source_code_d) ||
                      (rx_byte == cfg.source_code_e);

   // Next state and result for the byte at the input
   always_comb begin
      phase_in = phase_ff;
      pos_in   = pos_ff;
      len_in   = len_ff;
      sum_in   = sum_ff;
      stop_in  = stop_ff;
      src_in   = src_ff;
      cnt_in   = cnt_ff;
      drop_in  = drop_ff;
      result   = '0;
      case (phase_ff)
         PH_IDLE: begin
            pos_in  = '0;
            len_in  = '0;
            sum_in  = '0;
            stop_in = 1'b0;
            if (rx_byte == cfg.start_byte) phase_in = PH_DEST;
         end
         PH_DEST: begin
            if (rx_byte == cfg.own_address) begin
               phase_in = PH_SRC;
            end else begin
               phase_in = PH_IDLE;
               drop_in  = drop_ff + DROP_W'(1);
            end
         end
         PH_SRC: begin
            if (src_match) begin
               src_in   = rx_byte;
               phase_in = PH_COUNT;
            end else begin
               phase_in = PH_IDLE;
            end
         end
         PH_COUNT: begin
            cnt_in   = rx_byte;
            phase_in = PH_LEN_HI;
         end
         PH_LEN_HI: begin
            len_in   = {rx_byte, {(LENGTH_W-BYTE_W){1'b0}}};
            phase_in = PH_LEN_LO;
         end
         PH_LEN_LO: begin
            len_in = len_full;
            if (32'(len_full) > 32'(MAX_LENGTH)) begin
               result.error_now = 1'b1;
               phase_in         = PH_IDLE;
            end else begin
               phase_in = PH_DATA;
            end
         end
         PH_DATA: begin
            if (rx_byte == cfg.end_byte) begin
               // abort on end byte inside payload
               result.error_now = 1'b1;
               phase_in         = PH_IDLE;
            end else if (rx_byte == cfg.start_byte) begin
               // resync: restart at destination with a clean frame
               result.error_now = 1'b1;
               pos_in   = '0;
               len_in   = '0;
               sum_in   = '0;
               stop_in  = 1'b0;
               phase_in = PH_DEST;
            end else begin
               result.payload_valid  = 1'b1;
               result.payload_byte   = rx_byte;
               result.payload_offset = pos_ff;
               stop_in = stop_ff || (rx_byte == '0);
               if (!stop_in) sum_in = sum_ff + rx_byte;
               pos_in = pos_inc;
               if (pos_inc >= len_ff) begin
                  pos_in   = '0;
                  phase_in = PH_SUM;
               end
            end
         end
         PH_SUM: begin
            if (rx_byte != sum_ff) begin
               drop_in          = drop_ff + DROP_W'(1);
               result.error_now = 1'b1;
               phase_in         = PH_IDLE;
            end else begin
               phase_in = PH_END;
            end
         end
         PH_END: begin
            phase_in = PH_IDLE;
            if (rx_byte == cfg.end_byte) result.message_done = 1'b1;
            else                         result.error_now    = 1'b1;
         end
         default: begin
            phase_in = PH_IDLE;
         end
      endcase
      result.source_seen = src_in;
      result.count_seen  = cnt_in;
      result.drop_total  = drop_in;
   end

   // Advance the parse state on each accepted word
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         pos_ff   <= '0;
         len_ff   <= '0;
         sum_ff   <= '0;
         stop_ff  <= 1'b0;
         src_ff   <= '0;
         cnt_ff   <= '0;
         drop_ff  <= '0;
      end else if (accept) begin
         phase_ff <= phase_in;
         pos_ff   <= pos_in;
         len_ff   <= len_in;
         sum_ff   <= sum_in;
         stop_ff  <= stop_in;
         src_ff   <= src_in;
         cnt_ff   <= cnt_in;
         drop_ff  <= drop_in;
      end
   end

endmodule

// ----- sv/fmd_out_buf.sv -----
// Two-entry result register with skid slot, decoupling input from output stalls.
// Depends on fmd_pkg.
module fmd_out_buf (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  fmd_pkg::result_type push_data,
   output logic                space,
   output logic                out_valid,
   input  logic                out_ready,
   output fmd_pkg::result_type out_data
);
   import fmd_pkg::*;

   result_type head_ff, head_in;
   result_type skid_ff, skid_in;
   logic [1:0] fill_ff, fill_in;
   logic       pop;

   assign out_valid = (fill_ff != 2'd0);
   assign out_data  = head_ff;
   assign space     = (fill_ff != 2'd2);
   assign pop       = out_valid && out_ready;

   // Shift the skid word forward on a pop, land a new word behind the rest
   always_comb begin
      head_in = head_ff;
      skid_in = skid_ff;
      fill_in = fill_ff;
      case ({push, pop})
         2'b10: begin
            if (fill_ff == 2'd0) head_in = push_data;
            else                 skid_in = push_data;
            fill_in = fill_ff + 2'd1;
         end
         2'b01: begin
            head_in = skid_ff;
            fill_in = fill_ff - 2'd1;
         end
         2'b11: begin
            if (fill_ff == 2'd1) begin
               head_in = push_data;
            end else begin
               head_in = skid_ff;
               skid_in = push_data;
            end
         end
         default: begin
            fill_in = fill_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= 2'd0;
      end else begin
         fill_ff <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      head_ff <= head_in;
      skid_ff <= skid_in;
   end

endmodule
